[src/trs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package trs_pkg;
    localparam int RtSlots = 4;
    localparam int SlotBits = 2;
    localparam int LenBits = 11;
    localparam int NumStats = 15;
    localparam logic [7:0] IdRealtime = 8'h39;
    localparam logic [7:0] IdSecond = 8'h32;

    localparam logic [2:0] REQ_PUBLISH = 3'd0;
    localparam logic [2:0] REQ_SELECT = 3'd1;
    localparam logic [2:0] REQ_FINISH = 3'd2;
    localparam logic [2:0] REQ_CLEAR = 3'd3;
    localparam logic [2:0] REQ_STAT = 3'd4;

    localparam logic [1:0] CFG_MAX_LEN = 2'd0;
    localparam logic [1:0] CFG_MAX_AGE = 2'd1;
    localparam logic [1:0] CFG_MAX_BURST = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_BUMP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic start;
        logic [SlotBits-1:0] idx;
    } scan_ctl_t;

    typedef struct packed {
        logic found;
        logic [SlotBits-1:0] slot;
    } scan_res_t;
endpackage
`default_nettype wire

[src/trs_oldest_scan.sv]
`timescale 1ns / 1ps
`default_nettype none
module trs_oldest_scan (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire trs_pkg::scan_ctl_t ctl,
    input  wire logic rdy,
    input  wire logic [31:0] seq,
    output trs_pkg::scan_res_t res
);
    import trs_pkg::*;

    logic found_reg, found_next;
    logic [SlotBits-1:0] slot_reg, slot_next;
    logic [31:0] best_reg, best_next;

    always_comb
    begin
        found_next = ctl.start ? 1'b0 : found_reg;
        slot_next = slot_reg;
        best_next = best_reg;
        if (rdy && (!found_next || seq < best_reg))
        begin
            found_next = 1'b1;
            slot_next = ctl.idx;
            best_next = seq;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            found_reg <= 1'b0;
        else
            found_reg <= found_next;
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        best_reg <= best_next;
    end

    assign res.found = found_reg;
    assign res.slot = slot_reg;
endmodule
`default_nettype wire

[src/tx_report_scheduler.sv]
`timescale 1ns / 1ps
`default_nettype none
// Report descriptor scheduler. A request is accepted while s_tready is high. One
// comparator walks the realtime slots one per cycle to find the oldest entry, the
// decide state chooses the result, and the bump state updates the statistics
// counters. The result is held in an output register and s_tready stays low until
// that result has been taken, so a new request is not accepted before then. A
// select repeats the walk and the decide step once for every stale entry it
// drops.
module tx_report_scheduler (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic s_tvalid,
    output logic s_tready,
    // req_type, rpt_id, frame_len, now_ms, done_class, done_version,
    // success, stat_index, zero pad
    input  wire logic [95:0] s_tdata,
    output logic m_tvalid,
    input  wire logic m_tready,
    // ok, slot_index, out_class, out_len, out_version, out_created_ms,
    // out_sequence, pending_any, stat_value, zero pad
    output logic [151:0] m_tdata
);
    import trs_pkg::*;

    logic [10:0] max_len_reg;
    logic [15:0] max_age_reg;
    logic [7:0] max_burst_reg;

    logic [RtSlots-1:0] rt_ready_reg;
    logic [31:0] rt_seq_reg [RtSlots];
    logic [31:0] rt_created_reg [RtSlots];
    logic [LenBits-1:0] rt_len_reg [RtSlots];
    logic [1:0] mb_ready_reg;
    logic [31:0] mb_seq_reg [2];
    logic [31:0] mb_created_reg [2];
    logic [LenBits-1:0] mb_len_reg [2];
    logic [31:0] mb_fver_reg [2];
    logic [31:0] mb_vcnt_reg [2];
    logic [31:0] pub_cnt_reg;
    logic [7:0] burst_reg;
    logic prefer_reg;
    logic [31:0] stats_reg [NumStats];

    state_t state_reg, state_next;
    logic [SlotBits:0] idx_reg;
    logic [95:0] req_reg;
    logic [151:0] out_reg;
    logic out_valid_reg;
    logic bump_en_reg;
    logic [3:0] bump_idx_reg;

    logic [2:0] r_type;
    logic [7:0] r_id;
    logic [10:0] r_len;
    logic [31:0] r_now;
    logic [1:0] r_dcls;
    logic [31:0] r_dver;
    logic r_succ;
    logic [3:0] r_sidx;
    assign r_type = req_reg[2:0];
    assign r_id = req_reg[10:3];
    assign r_len = req_reg[21:11];
    assign r_now = req_reg[53:22];
    assign r_dcls = req_reg[55:54];
    assign r_dver = req_reg[87:56];
    assign r_succ = req_reg[88];
    assign r_sidx = req_reg[92:89];

    scan_ctl_t sc;
    scan_res_t sr;
    logic [SlotBits-1:0] sidx;
    assign sidx = idx_reg[SlotBits-1:0];
    assign sc.start = (state_reg == ST_SCAN) && (idx_reg == '0);
    assign sc.idx = sidx;

    trs_oldest_scan u_scan (
        .clk(clk), .rst_n(rst_n), .ctl(sc),
        .rdy((state_reg == ST_SCAN) && rt_ready_reg[sidx]),
        .seq(rt_seq_reg[sidx]), .res(sr)
    );

    logic scan_last;
    assign scan_last = (idx_reg == (SlotBits+1)'(RtSlots - 1));

    // decide-stage helpers
    logic [RtSlots-1:0] free_vec;
    logic has_free;
    logic [SlotBits-1:0] free_slot;
    always_comb
    begin
        has_free = 1'b0;
        free_slot = '0;
        free_vec = ~rt_ready_reg;
        for (int i = RtSlots - 1; i >= 0; i--)
            if (free_vec[i])
            begin
                has_free = 1'b1;
                free_slot = SlotBits'(i);
            end
    end

    logic rt_mode_reg;      // select is currently working on realtime
    logic tried_mb_reg;     // mailbox already tried and empty
    logic [31:0] age;
    assign age = r_now - rt_created_reg[sr.slot];

    logic [SlotBits-1:0] pub_slot;
    logic pub_mb;
    assign pub_slot = has_free ? free_slot : sr.slot;
    assign pub_mb = (r_id == IdSecond);

    logic sel_mbp, sel_use_rt, sel_mm, sel_stale, sel_rt, sel_mb, sel_retry, rescan;
    assign sel_mbp = |mb_ready_reg;
    assign sel_use_rt = rt_mode_reg ||
        (!tried_mb_reg && (burst_reg < max_burst_reg || !sel_mbp)) || tried_mb_reg;
    assign sel_mm = mb_ready_reg[prefer_reg] ? prefer_reg : !prefer_reg;
    assign sel_stale = age > {16'd0, max_age_reg};
    assign sel_rt = sel_use_rt && sr.found;
    assign sel_mb = !sel_rt && !tried_mb_reg && mb_ready_reg[sel_mm];
    assign sel_retry = !sel_rt && !sel_mb && !tried_mb_reg && !rt_mode_reg && sr.found;
    assign rescan = (r_type == REQ_SELECT) && ((sel_rt && sel_stale) || sel_retry);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_tvalid && s_tready) state_next = ST_SCAN;
            ST_SCAN: if (scan_last) state_next = ST_DECIDE;
            ST_DECIDE: state_next = rescan ? ST_SCAN : ST_BUMP;
            ST_BUMP: state_next = ST_DONE;
            ST_DONE: if (!out_valid_reg) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= 11'd128;
            max_age_reg <= 16'd10;
            max_burst_reg <= 8'd4;
            rt_ready_reg <= '0;
            mb_ready_reg <= '0;
            mb_vcnt_reg[0] <= '0;
            mb_vcnt_reg[1] <= '0;
            pub_cnt_reg <= '0;
            burst_reg <= '0;
            prefer_reg <= 1'b0;
            for (int i = 0; i < NumStats; i++) stats_reg[i] <= '0;
            state_reg <= ST_IDLE;
            idx_reg <= '0;
            out_valid_reg <= 1'b0;
            bump_en_reg <= 1'b0;
            bump_idx_reg <= '0;
            rt_mode_reg <= 1'b0;
            tried_mb_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MAX_LEN: max_len_reg <= cfg_data[10:0];
                    CFG_MAX_AGE: max_age_reg <= cfg_data;
                    CFG_MAX_BURST: max_burst_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    idx_reg <= '0;
                    bump_en_reg <= 1'b0;
                    tried_mb_reg <= 1'b0;
                    rt_mode_reg <= 1'b0;
                end
                ST_SCAN:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    out_reg <= '0;
                end
                ST_DECIDE:
                begin
                    idx_reg <= '0;
                    case (r_type)
                        REQ_PUBLISH:
                        begin
                            if (r_len != 0 && r_len <= max_len_reg)
                            begin
                                pub_cnt_reg <= pub_cnt_reg + 1'b1;
                                out_reg[0] <= 1'b1;
                                out_reg[16:6] <= r_len;
                                out_reg[80:49] <= r_now;
                                out_reg[112:81] <= pub_cnt_reg + 1'b1;
                                bump_en_reg <= 1'b1;
                                if (r_id == IdRealtime)
                                begin
                                    if (!has_free)
                                        stats_reg[4'd1] <= stats_reg[4'd1] + 1'b1;
                                    rt_ready_reg[pub_slot] <= 1'b1;
                                    rt_seq_reg[pub_slot] <= pub_cnt_reg + 1'b1;
                                    rt_created_reg[pub_slot] <= r_now;
                                    rt_len_reg[pub_slot] <= r_len;
                                    out_reg[3:1] <= 3'(pub_slot);
                                    bump_idx_reg <= 4'd0;
                                end
                                else
                                begin
                                    if (mb_ready_reg[pub_mb])
                                        stats_reg[pub_mb ? 4'd11 : 4'd6] <=
                                            stats_reg[pub_mb ? 4'd11 : 4'd6] + 1'b1;
                                    mb_vcnt_reg[pub_mb] <= mb_vcnt_reg[pub_mb] + 1'b1;
                                    mb_ready_reg[pub_mb] <= 1'b1;
                                    mb_seq_reg[pub_mb] <= pub_cnt_reg + 1'b1;
                                    mb_created_reg[pub_mb] <= r_now;
                                    mb_len_reg[pub_mb] <= r_len;
                                    mb_fver_reg[pub_mb] <= mb_vcnt_reg[pub_mb] + 1'b1;
                                    out_reg[3:1] <= 3'(RtSlots + 32'(pub_mb));
                                    out_reg[5:4] <= {pub_mb, !pub_mb};
                                    out_reg[48:17] <= mb_vcnt_reg[pub_mb] + 1'b1;
                                    bump_idx_reg <= pub_mb ? 4'd10 : 4'd5;
                                end
                            end
                        end
                        REQ_SELECT:
                        begin
                            if (sel_rt)
                            begin
                                rt_ready_reg[sr.slot] <= 1'b0;
                                if (sel_stale)
                                begin
                                    stats_reg[4'd2] <= stats_reg[4'd2] + 1'b1;
                                    rt_mode_reg <= 1'b1;
                                end
                                else
                                begin
                                    out_reg[0] <= 1'b1;
                                    out_reg[3:1] <= 3'(sr.slot);
                                    out_reg[16:6] <= rt_len_reg[sr.slot];
                                    out_reg[80:49] <= rt_created_reg[sr.slot];
                                    out_reg[112:81] <= rt_seq_reg[sr.slot];
                                    if (burst_reg != 8'hFF)
                                        burst_reg <= burst_reg + 1'b1;
                                end
                            end
                            else if (sel_mb)
                            begin
                                out_reg[0] <= 1'b1;
                                out_reg[3:1] <= 3'(RtSlots + 32'(sel_mm));
                                out_reg[5:4] <= {sel_mm, !sel_mm};
                                out_reg[16:6] <= mb_len_reg[sel_mm];
                                out_reg[48:17] <= mb_fver_reg[sel_mm];
                                out_reg[80:49] <= mb_created_reg[sel_mm];
                                out_reg[112:81] <= mb_seq_reg[sel_mm];
                                prefer_reg <= !sel_mm;
                                burst_reg <= '0;
                            end
                            else if (sel_retry)
                            begin
                                tried_mb_reg <= 1'b1;
                            end
                        end
                        REQ_FINISH:
                        begin
                            if (r_dcls != 2'd3)
                            begin
                                out_reg[0] <= 1'b1;
                                bump_en_reg <= 1'b1;
                                bump_idx_reg <= 4'(r_dcls * 5 + (r_succ ? 3 : 4));
                                if (r_succ && r_dcls != 2'd0)
                                begin
                                    if (mb_ready_reg[r_dcls[1]] &&
                                        mb_fver_reg[r_dcls[1]] == r_dver)
                                        mb_ready_reg[r_dcls[1]] <= 1'b0;
                                end
                            end
                        end
                        REQ_CLEAR:
                        begin
                            out_reg[0] <= 1'b1;
                            rt_ready_reg <= '0;
                            mb_ready_reg <= '0;
                            burst_reg <= '0;
                            prefer_reg <= 1'b0;
                        end
                        REQ_STAT:
                        begin
                            if (r_sidx != 4'd15)
                            begin
                                out_reg[0] <= 1'b1;
                                out_reg[145:114] <= stats_reg[r_sidx];
                            end
                        end
                        default: ;
                    endcase
                end
                ST_BUMP:
                begin
                    if (bump_en_reg)
                        stats_reg[bump_idx_reg] <= stats_reg[bump_idx_reg] + 1'b1;
                    bump_en_reg <= 1'b0;
                    out_reg[113] <= (|rt_ready_reg) || (|mb_ready_reg);
                    out_valid_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready) req_reg <= s_tdata;
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (state_reg == ST_IDLE)) else $error("ready while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid) else $error("result lost");
    a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready) else $error("accept with result pending");
endmodule
`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 1ps
module tb;
    import trs_pkg::*;

    localparam int DrainCycles = 40;

    typedef struct {
        logic [2:0]  req;
        logic [7:0]  id;
        logic [10:0] len;
        logic [31:0] now;
        logic [1:0]  dcls;
        logic [31:0] dver;
        logic        success;
        logic [3:0]  stat;
    } request_t;

    typedef struct {
        logic        ok;
        logic [2:0]  slot;
        logic [1:0]  cls;
        logic [10:0] len;
        logic [31:0] version;
        logic [31:0] created;
        logic [31:0] sequence_no;
        logic        pending;
        logic [31:0] stat_value;
    } outcome_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [15:0] cfg_data;
    logic s_tvalid;
    logic s_tready;
    logic [95:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [151:0] m_tdata;

    tx_report_scheduler dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    // scheduler shadow state
    logic [10:0] lim_len;
    logic [15:0] lim_age;
    logic [7:0]  lim_burst;
    logic        rt_rdy [RtSlots];
    logic [31:0] rt_sq [RtSlots];
    logic [31:0] rt_born [RtSlots];
    logic [10:0] rt_len [RtSlots];
    logic        mb_rdy [2];
    logic [31:0] mb_sq [2];
    logic [31:0] mb_born [2];
    logic [10:0] mb_len [2];
    logic [31:0] mb_ver [2];
    logic [31:0] mb_vcount [2];
    logic [31:0] pub_count;
    logic [7:0]  burst;
    logic        prefer_b;
    logic [31:0] counters [NumStats];

    outcome_t expected_q[$];
    int fails;
    bit send_fast;
    bit recv_fast;
    int stall_left;
    logic [31:0] clock_ms;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    function automatic void shadow_reset();
        lim_len = 11'd128;
        lim_age = 16'd10;
        lim_burst = 8'd4;
        for (int i = 0; i < RtSlots; i++)
        begin
            rt_rdy[i] = 1'b0;
        end
        mb_rdy[0] = 1'b0;
        mb_rdy[1] = 1'b0;
        mb_ver[0] = '0;
        mb_ver[1] = '0;
        mb_vcount[0] = '0;
        mb_vcount[1] = '0;
        pub_count = '0;
        burst = '0;
        prefer_b = 1'b0;
        for (int i = 0; i < NumStats; i++)
        begin
            counters[i] = '0;
        end
    endfunction

    function automatic int oldest_rt();
        int best;
        best = -1;
        for (int i = 0; i < RtSlots; i++)
        begin
            if (rt_rdy[i] && (best < 0 || rt_sq[i] < rt_sq[best]))
                best = i;
        end
        return best;
    endfunction

    function automatic bit take_rt(input logic [31:0] now, inout outcome_t o);
        int s;
        logic [31:0] age;
        forever
        begin
            s = oldest_rt();
            if (s < 0)
                return 1'b0;
            rt_rdy[s] = 1'b0;
            age = now - rt_born[s];
            if (age > {16'd0, lim_age})
            begin
                counters[2]++;
            end
            else
            begin
                o.ok = 1'b1;
                o.slot = 3'(s);
                o.cls = 2'd0;
                o.len = rt_len[s];
                o.version = '0;
                o.created = rt_born[s];
                o.sequence_no = rt_sq[s];
                if (burst != 8'd255)
                    burst++;
                return 1'b1;
            end
        end
    endfunction

    function automatic bit take_mbox(inout outcome_t o);
        int m;
        m = prefer_b ? 1 : 0;
        if (!mb_rdy[m])
            m = 1 - m;
        if (!mb_rdy[m])
            return 1'b0;
        o.ok = 1'b1;
        o.slot = 3'(RtSlots + m);
        o.cls = 2'(m + 1);
        o.len = mb_len[m];
        o.version = mb_ver[m];
        o.created = mb_born[m];
        o.sequence_no = mb_sq[m];
        prefer_b = (m == 0);
        burst = '0;
        return 1'b1;
    endfunction

    function automatic outcome_t schedule(input request_t r);
        outcome_t o;
        int s;
        int m;
        bit hit;
        o = '{default: '0};
        case (r.req)
            REQ_PUBLISH:
            begin
                if (r.len != 0 && r.len <= lim_len)
                begin
                    pub_count++;
                    o.ok = 1'b1;
                    o.len = r.len;
                    o.created = r.now;
                    o.sequence_no = pub_count;
                    if (r.id == IdRealtime)
                    begin
                        s = -1;
                        for (int i = 0; i < RtSlots; i++)
                        begin
                            if (s < 0 && !rt_rdy[i])
                                s = i;
                        end
                        if (s < 0)
                        begin
                            s = oldest_rt();
                            counters[1]++;
                        end
                        rt_rdy[s] = 1'b1;
                        rt_sq[s] = pub_count;
                        rt_born[s] = r.now;
                        rt_len[s] = r.len;
                        o.slot = 3'(s);
                        counters[0]++;
                    end
                    else
                    begin
                        m = (r.id == IdSecond) ? 1 : 0;
                        if (mb_rdy[m])
                            counters[(m + 1) * 5 + 1]++;
                        mb_vcount[m]++;
                        mb_rdy[m] = 1'b1;
                        mb_sq[m] = pub_count;
                        mb_born[m] = r.now;
                        mb_len[m] = r.len;
                        mb_ver[m] = mb_vcount[m];
                        o.slot = 3'(RtSlots + m);
                        o.cls = 2'(m + 1);
                        o.version = mb_vcount[m];
                        counters[(m + 1) * 5]++;
                    end
                end
            end
            REQ_SELECT:
            begin
                hit = 1'b0;
                if (burst < lim_burst || !(mb_rdy[0] || mb_rdy[1]))
                    hit = take_rt(r.now, o);
                if (!hit)
                    hit = take_mbox(o);
                if (!hit)
                    hit = take_rt(r.now, o);
            end
            REQ_FINISH:
            begin
                if (r.dcls != 2'd3)
                begin
                    o.ok = 1'b1;
                    if (r.success)
                    begin
                        counters[r.dcls * 5 + 3]++;
                        if (r.dcls != 2'd0)
                        begin
                            m = r.dcls - 1;
                            if (mb_rdy[m] && mb_ver[m] == r.dver)
                                mb_rdy[m] = 1'b0;
                        end
                    end
                    else
                    begin
                        counters[r.dcls * 5 + 4]++;
                    end
                end
            end
            REQ_CLEAR:
            begin
                for (int i = 0; i < RtSlots; i++)
                begin
                    rt_rdy[i] = 1'b0;
                end
                mb_rdy[0] = 1'b0;
                mb_rdy[1] = 1'b0;
                burst = '0;
                prefer_b = 1'b0;
                o.ok = 1'b1;
            end
            REQ_STAT:
            begin
                if (r.stat < NumStats)
                begin
                    o.ok = 1'b1;
                    o.stat_value = counters[r.stat];
                end
            end
            default:
            begin
            end
        endcase
        o.pending = mb_rdy[0] || mb_rdy[1];
        for (int i = 0; i < RtSlots; i++)
        begin
            if (rt_rdy[i])
                o.pending = 1'b1;
        end
        return o;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        if (fails < 40)
            $display("%0t: %s got %0h expected %0h", $realtime, field, got, want);
        fails++;
    endtask

    always @(posedge clk)
    begin
        outcome_t got;
        outcome_t want;
        if (m_tvalid && m_tready)
        begin
            got.ok = m_tdata[0];
            got.slot = m_tdata[3:1];
            got.cls = m_tdata[5:4];
            got.len = m_tdata[16:6];
            got.version = m_tdata[48:17];
            got.created = m_tdata[80:49];
            got.sequence_no = m_tdata[112:81];
            got.pending = m_tdata[113];
            got.stat_value = m_tdata[145:114];
            if (expected_q.size() == 0)
            begin
                report_mismatch("unexpected result", 32'd0, 32'd0);
            end
            else
            begin
                want = expected_q.pop_front();
                if (got.ok !== want.ok)
                    report_mismatch("ok", got.ok, want.ok);
                if (got.slot !== want.slot)
                    report_mismatch("slot_index", got.slot, want.slot);
                if (got.cls !== want.cls)
                    report_mismatch("out_class", got.cls, want.cls);
                if (got.len !== want.len)
                    report_mismatch("out_len", got.len, want.len);
                if (got.version !== want.version)
                    report_mismatch("out_version", got.version, want.version);
                if (got.created !== want.created)
                    report_mismatch("out_created_ms", got.created, want.created);
                if (got.sequence_no !== want.sequence_no)
                    report_mismatch("out_sequence", got.sequence_no, want.sequence_no);
                if (got.pending !== want.pending)
                    report_mismatch("pending_any", got.pending, want.pending);
                if (got.stat_value !== want.stat_value)
                    report_mismatch("stat_value", got.stat_value, want.stat_value);
            end
            stall_left = recv_fast ? 0 : $urandom_range(0, 14);
            if (stall_left > 0)
                m_tready <= 1'b0;
        end
        else if (!m_tready && rst_n)
        begin
            if (stall_left <= 1)
                m_tready <= 1'b1;
            stall_left--;
        end
    end

    task automatic send_request(input request_t r);
        int gap;
        gap = send_fast ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata <= {3'b0, r.stat, r.success, r.dver, r.dcls, r.now, r.len, r.id, r.req};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        expected_q.push_back(schedule(r));
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [15:0] value);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (index)
            CFG_MAX_LEN: lim_len = value[10:0];
            CFG_MAX_AGE: lim_age = value;
            CFG_MAX_BURST: lim_burst = value[7:0];
            default:
            begin
            end
        endcase
        @(posedge clk);
    endtask

    task automatic configure(input logic [10:0] max_len, input logic [15:0] max_age,
                             input logic [7:0] max_burst);
        wait_idle();
        write_reg(CFG_MAX_LEN, {5'd0, max_len});
        write_reg(CFG_MAX_AGE, max_age);
        write_reg(CFG_MAX_BURST, {8'd0, max_burst});
    endtask

    function automatic request_t make_req(input logic [2:0] req, input logic [7:0] id,
                                          input logic [10:0] len, input logic [31:0] now);
        request_t r;
        r = '{default: '0};
        r.req = req;
        r.id = id;
        r.len = len;
        r.now = now;
        return r;
    endfunction

    function automatic request_t make_done(input logic [1:0] cls, input logic [31:0] ver,
                                           input logic ok_tx);
        request_t r;
        r = make_req(REQ_FINISH, 8'd0, 11'd0, 32'd0);
        r.dcls = cls;
        r.dver = ver;
        r.success = ok_tx;
        return r;
    endfunction

    function automatic request_t make_stat(input logic [3:0] idx);
        request_t r;
        r = make_req(REQ_STAT, 8'd0, 11'd0, 32'd0);
        r.stat = idx;
        return r;
    endfunction

    task automatic test_directed();
        logic [31:0] t;
        t = 32'hFFFF_FFFA;
        for (int i = 0; i < 5; i++)
        begin
            send_request(make_req(REQ_PUBLISH, IdRealtime, 11'(i + 1), t + i));
        end
        send_request(make_req(REQ_PUBLISH, IdSecond, 11'd128, t));
        send_request(make_req(REQ_PUBLISH, 8'hFF, 11'd1, t));
        send_request(make_req(REQ_PUBLISH, 8'h00, 11'd0, t));
        send_request(make_req(REQ_PUBLISH, 8'h00, 11'd129, t));
        send_request(make_req(REQ_PUBLISH, 8'h31, 11'h7FF, t));
        send_request(make_req(REQ_PUBLISH, 8'h00, 11'd100, t));
        for (int i = 0; i < 6; i++)
        begin
            send_request(make_req(REQ_SELECT, 8'd0, 11'd0, t + 32'd12));
        end
        send_request(make_done(2'd2, mb_ver[1], 1'b1));
        send_request(make_done(2'd1, 32'hFFFF_FFFF, 1'b1));
        send_request(make_done(2'd0, 32'd0, 1'b0));
        send_request(make_done(2'd3, 32'hFFFF_FFFF, 1'b1));
        send_request(make_stat(4'd14));
        send_request(make_stat(4'd15));
        send_request(make_req(3'd5, 8'hFF, 11'h7FF, 32'hFFFF_FFFF));
        send_request(make_req(3'd7, 8'd0, 11'd0, 32'd0));
        send_request(make_req(REQ_CLEAR, 8'd0, 11'd0, 32'd0));
        send_request(make_req(REQ_SELECT, 8'd0, 11'd0, 32'd0));
    endtask

    function automatic request_t random_request();
        request_t r;
        int pick;
        int kind;
        pick = $urandom_range(0, 99);
        r = '{default: '0};
        if (pick < 45)
        begin
            kind = $urandom_range(0, 9);
            r.req = REQ_PUBLISH;
            r.id = (kind < 5) ? IdRealtime : (kind < 7) ? IdSecond : 8'($urandom);
            r.len = 11'($urandom_range(1, lim_len));
            if ($urandom_range(0, 19) == 0)
                r.len = 11'($urandom);
            clock_ms += $urandom_range(0, 4);
            r.now = clock_ms;
        end
        else if (pick < 80)
        begin
            r.req = REQ_SELECT;
            clock_ms += ($urandom_range(0, 9) == 0) ? 32'($urandom_range(0, 70000))
                                                   : 32'($urandom_range(0, 5));
            r.now = clock_ms;
        end
        else if (pick < 92)
        begin
            r.req = REQ_FINISH;
            r.dcls = 2'($urandom_range(0, 2));
            r.dver = (r.dcls != 0 && $urandom_range(0, 4) != 0) ? mb_ver[r.dcls - 1]
                                                               : 32'($urandom);
            r.success = ($urandom_range(0, 4) != 0);
            if ($urandom_range(0, 19) == 0)
                r.dcls = 2'd3;
        end
        else if (pick < 95)
        begin
            r.req = REQ_CLEAR;
        end
        else if (pick < 98)
        begin
            r.req = REQ_STAT;
            r.stat = 4'($urandom);
        end
        else
        begin
            r = '{req: 3'($urandom_range(5, 7)), id: 8'($urandom), len: 11'($urandom),
                  now: $urandom, dcls: 2'($urandom), dver: $urandom,
                  success: 1'($urandom), stat: 4'($urandom)};
        end
        return r;
    endfunction

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
            begin
                send_fast = ($urandom_range(0, 3) == 0);
                recv_fast = ($urandom_range(0, 3) == 0);
            end
            send_request(random_request());
        end
    endtask

    task automatic test_config_sweep();
        configure(11'd1024, 16'd0, 8'd1);
        test_random(100);
        configure(11'd1, 16'd65535, 8'd255);
        test_random(60);
        configure(11'($urandom_range(1, 1024)), 16'($urandom_range(0, 30)),
                  8'($urandom_range(1, 6)));
        test_random(120);
        for (int i = 0; i < 15; i++)
        begin
            send_request(make_stat(4'(i)));
        end
    endtask

    initial
    begin
        shadow_reset();
        fails = 0;
        send_fast = 1'b0;
        recv_fast = 1'b0;
        stall_left = 0;
        clock_ms = $urandom;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        m_tready <= 1'b1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        configure(11'd128, 16'd10, 8'd4);
        test_random(230);
        test_config_sweep();
        wait_idle();
        if (fails == 0 && expected_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
